// ===== hdl/long_to_radix_digits_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the long_to_radix_digits unit
// Shared concurrent check forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LONG_TO_RADIX_DIGITS_UNIT_DEFINES_SVH
`define LONG_TO_RADIX_DIGITS_UNIT_DEFINES_SVH

// same-cycle implication
`define LTRD_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LTRD_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ltrd_pkg.sv =====
// ---------------------------------------------------------------------------
// ltrd_pkg
// Types and constants of the radix digit conversion unit.
// ---------------------------------------------------------------------------
package ltrd_pkg;

  localparam int DEF_VALUE_WIDTH = 32;
  localparam int RADIX_W         = 6;
  localparam int DIGIT_W         = 6;

  localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;
  localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;

  typedef enum logic [1:0] {
    KIND_DIGIT = 2'd0,
    KIND_SIGN  = 2'd1,
    KIND_ZERO  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_ZERO,
    ST_SHIFT,
    ST_DIV,
    ST_DIGIT
  } state_t;

endpackage

// ===== hdl/ltrd_if.sv =====
// ---------------------------------------------------------------------------
// ltrd channel interfaces
// Valid/ready channels for input items and result items.
// ---------------------------------------------------------------------------
interface ltrd_in_if #(
  parameter int VALUE_WIDTH = ltrd_pkg::DEF_VALUE_WIDTH
);
  logic                              valid;
  logic                              ready;
  logic signed [VALUE_WIDTH-1:0]     value;
  logic [ltrd_pkg::RADIX_W-1:0]      radix;
  logic                              is_signed;

  modport source (output valid, value, radix, is_signed, input ready);
  modport sink   (input valid, value, radix, is_signed, output ready);
endinterface

interface ltrd_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        kind;
  logic [ltrd_pkg::DIGIT_W-1:0]      digit;
  logic                              last;

  modport source (output valid, kind, digit, last, input ready);
  modport sink   (input valid, kind, digit, last, output ready);
endinterface

// ===== hdl/long_to_radix_digits_unit.sv =====
// Base 16 and 8 give one digit per cycle while the output is not stalled.
// Other bases: a bit-serial restoring divider works out each digit in ST_DIV, then
//   hands it over in ST_DIGIT, which waits while the output is stalled.
// One item is in work at a time; the next is taken once its last result is registered.
// Reset: rst_n synchronous, active low; clears the state machine and output valid.
// ---------------------------------------------------------------------------
// long_to_radix_digits_unit
// Converts a value to its digit values, least significant first.
// ---------------------------------------------------------------------------
`include "long_to_radix_digits_unit_defines.svh"

module long_to_radix_digits_unit #(
  parameter int VALUE_WIDTH = ltrd_pkg::DEF_VALUE_WIDTH
) (
  input  logic         clk,
  input  logic         rst_n,
  ltrd_in_if.sink      in_ch,
  ltrd_out_if.source   out_ch
);

  localparam int W          = VALUE_WIDTH;
  localparam int HEX_DIGITS = (W + 3) / 4;
  localparam int OCT_DIGITS = (W + 2) / 3;
  localparam int HEX_REM    = W - 4 * (HEX_DIGITS - 1);
  localparam int OCT_REM    = W - 3 * (OCT_DIGITS - 1);
  localparam logic [3:0] HEX_MASK = 4'((1 << HEX_REM) - 1);
  localparam logic [2:0] OCT_MASK = 3'((1 << OCT_REM) - 1);
  localparam int BCNT_W     = $clog2(W);
  localparam int DCNT_W     = $clog2(OCT_DIGITS);
  localparam int RW         = ltrd_pkg::RADIX_W;
  localparam int DW         = ltrd_pkg::DIGIT_W;

  ltrd_pkg::state_t state_r, state_nxt;

  logic [W-1:0]      n_r, n_nxt;
  logic [DW-1:0]     rem_r, rem_nxt;
  logic [RW-1:0]     base_r, base_nxt;
  logic              hex_r, hex_nxt;
  logic [BCNT_W-1:0] bcnt_r, bcnt_nxt;
  logic [DCNT_W-1:0] dcnt_r, dcnt_nxt;

  logic              out_valid_r, out_valid_nxt;
  ltrd_pkg::kind_t   out_kind_r;
  logic [DW-1:0]     out_digit_r;
  logic              out_last_r;

  logic              in_acc;
  logic              out_free;
  logic              emit;
  ltrd_pkg::kind_t   e_kind;
  logic [DW-1:0]     e_digit;
  logic              e_last;

  logic              in_zero;
  logic              in_shift;
  logic              in_neg;
  logic              shift_lim;
  logic              shift_last;
  logic              q_zero;
  logic              bit_done;
  logic [DW:0]       trial;
  logic              trial_ge;

  assign in_ch.ready = (state_r == ltrd_pkg::ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign in_zero  = ~|in_ch.value;
  assign in_shift = (in_ch.radix == ltrd_pkg::RADIX_HEX) ||
                    (in_ch.radix == ltrd_pkg::RADIX_OCT);
  assign in_neg   = in_ch.is_signed && in_ch.value[W-1];

  assign shift_lim  = hex_r ? (dcnt_r == DCNT_W'(HEX_DIGITS - 1))
                            : (dcnt_r == DCNT_W'(OCT_DIGITS - 1));
  assign shift_last = shift_lim || (hex_r ? ~|n_r[W-1:4] : ~|n_r[W-1:3]);
  assign q_zero     = ~|n_r;
  assign bit_done   = (bcnt_r == BCNT_W'(W - 1));

  // one restoring division step
  assign trial    = {rem_r, n_r[W-1]};
  assign trial_ge = (trial >= {1'b0, base_r});

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ltrd_pkg::ST_IDLE: begin
        if (in_acc) begin
          priority if (in_zero)   state_nxt = ltrd_pkg::ST_ZERO;
          else if (in_shift)      state_nxt = ltrd_pkg::ST_SHIFT;
          else if (in_neg)        state_nxt = ltrd_pkg::ST_SIGN;
          else                    state_nxt = ltrd_pkg::ST_DIV;
        end
      end
      ltrd_pkg::ST_SIGN: begin
        if (out_free) state_nxt = ltrd_pkg::ST_DIV;
      end
      ltrd_pkg::ST_ZERO: begin
        if (out_free) state_nxt = ltrd_pkg::ST_IDLE;
      end
      ltrd_pkg::ST_SHIFT: begin
        if (out_free && shift_last) state_nxt = ltrd_pkg::ST_IDLE;
      end
      ltrd_pkg::ST_DIV: begin
        if (bit_done) state_nxt = ltrd_pkg::ST_DIGIT;
      end
      ltrd_pkg::ST_DIGIT: begin
        if (out_free) state_nxt = q_zero ? ltrd_pkg::ST_IDLE : ltrd_pkg::ST_DIV;
      end
      default: state_nxt = ltrd_pkg::ST_IDLE;
    endcase
  end

  // datapath and result
  always_comb begin
    n_nxt    = n_r;
    rem_nxt  = rem_r;
    base_nxt = base_r;
    hex_nxt  = hex_r;
    bcnt_nxt = bcnt_r;
    dcnt_nxt = dcnt_r;
    emit     = 1'b0;
    e_kind   = ltrd_pkg::KIND_DIGIT;
    e_digit  = '0;
    e_last   = 1'b0;
    unique case (state_r)
      ltrd_pkg::ST_IDLE: begin
        if (in_acc) begin
          base_nxt = (in_ch.radix < ltrd_pkg::RADIX_MIN) ? ltrd_pkg::RADIX_MIN
                                                         : in_ch.radix;
          hex_nxt  = (in_ch.radix == ltrd_pkg::RADIX_HEX);
          n_nxt    = (!in_shift && in_neg) ? (~in_ch.value + W'(1))
                                           : in_ch.value;
          rem_nxt  = '0;
          bcnt_nxt = '0;
          dcnt_nxt = '0;
        end
      end
      ltrd_pkg::ST_SIGN: begin
        emit   = out_free;
        e_kind = ltrd_pkg::KIND_SIGN;
      end
      ltrd_pkg::ST_ZERO: begin
        emit   = out_free;
        e_kind = ltrd_pkg::KIND_ZERO;
        e_last = 1'b1;
      end
      ltrd_pkg::ST_SHIFT: begin
        emit   = out_free;
        e_last = shift_last;
        if (hex_r) begin
          e_digit = DW'(shift_lim ? (n_r[3:0] & HEX_MASK) : n_r[3:0]);
        end else begin
          e_digit = DW'(shift_lim ? (n_r[2:0] & OCT_MASK) : n_r[2:0]);
        end
        if (out_free) begin
          n_nxt    = hex_r ? {{4{n_r[W-1]}}, n_r[W-1:4]}
                           : {{3{n_r[W-1]}}, n_r[W-1:3]};
          dcnt_nxt = dcnt_r + DCNT_W'(1);
        end
      end
      ltrd_pkg::ST_DIV: begin
        rem_nxt  = trial_ge ? DW'(trial - {1'b0, base_r}) : trial[DW-1:0];
        n_nxt    = {n_r[W-2:0], trial_ge};
        bcnt_nxt = bcnt_r + BCNT_W'(1);
      end
      ltrd_pkg::ST_DIGIT: begin
        emit    = out_free;
        e_digit = rem_r;
        e_last  = q_zero;
        if (out_free) begin
          rem_nxt  = '0;
          bcnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = emit || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ltrd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    base_r <= base_nxt;
    hex_r  <= hex_nxt;
    bcnt_r <= bcnt_nxt;
    dcnt_r <= dcnt_nxt;
    if (emit) begin
      out_kind_r  <= e_kind;
      out_digit_r <= e_digit;
      out_last_r  <= e_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.kind  = out_kind_r;
  assign out_ch.digit = out_digit_r;
  assign out_ch.last  = out_last_r;

  `LTRD_ASSERT_IMP(a_rem_below_base, clk, rst_n, state_r == ltrd_pkg::ST_DIV, rem_r < base_r, "remainder not below base")
  `LTRD_ASSERT_IMP(a_sign_not_last, clk, rst_n, out_valid_r && out_kind_r == ltrd_pkg::KIND_SIGN, !out_last_r && out_digit_r == '0, "minus marker ends run")
  `LTRD_ASSERT_IMP(a_zero_alone, clk, rst_n, out_valid_r && out_kind_r == ltrd_pkg::KIND_ZERO, out_last_r && out_digit_r == '0, "zero marker not a lone result")
  `LTRD_ASSERT_NXT(a_accept_busy, clk, rst_n, in_acc, state_r != ltrd_pkg::ST_IDLE, "accepted item left no work")

endmodule

// ===== tb/long_to_radix_digits_unit_tb.sv =====
// ---------------------------------------------------------------------------
// long_to_radix_digits_unit_tb
// Drives value/radix/sign items into the digit converter, predicts the digit
// run of each accepted item and checks every result transfer in order.
// Covers the hex and octal shift paths, division bases with sign markers and
// zero values, out-of-range bases, random idling and a long output stall.
// ---------------------------------------------------------------------------
module long_to_radix_digits_unit_tb;

  localparam int VW         = ltrd_pkg::DEF_VALUE_WIDTH;
  localparam int DW         = ltrd_pkg::DIGIT_W;
  localparam int RW         = ltrd_pkg::RADIX_W;
  localparam int HEX_DIGITS = (VW + 3) / 4;
  localparam int OCT_DIGITS = (VW + 2) / 3;
  localparam int RUN_MAX    = VW + 1;
  localparam int HOLD_LEN   = 300;

  typedef struct {
    ltrd_pkg::kind_t kind;
    logic [DW-1:0]   digit;
    logic            last;
  } digit_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ltrd_in_if #(.VALUE_WIDTH(VW)) in_ch ();
  ltrd_out_if                    out_ch ();

  long_to_radix_digits_unit #(.VALUE_WIDTH(VW)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  digit_result_t digits_pending[$];
  int unsigned   mismatch_count = 0;
  bit            tx_idle_en     = 1'b1;
  bit            rx_idle_en     = 1'b1;
  bit            rx_hold_req    = 1'b0;

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // expected digit run of one item, queued in transfer order
  function automatic void predict_digits(input logic [VW-1:0] v,
                                         input logic [RW-1:0] r,
                                         input logic s);
    logic [VW-1:0]        n;
    logic signed [VW-1:0] sn;
    logic [VW-1:0]        base;
    ltrd_pkg::kind_t      k [RUN_MAX];
    logic [DW-1:0]        d [RUN_MAX];
    int                   cnt;
    int                   lim;
    int                   sh;
    int                   rem;
    digit_result_t        res;
    n   = v;
    cnt = 0;
    if (r == ltrd_pkg::RADIX_HEX || r == ltrd_pkg::RADIX_OCT) begin
      sh  = (r == ltrd_pkg::RADIX_HEX) ? 4 : 3;
      lim = (r == ltrd_pkg::RADIX_HEX) ? HEX_DIGITS : OCT_DIGITS;
      while (n != 0 && cnt < lim) begin
        k[cnt] = ltrd_pkg::KIND_DIGIT;
        d[cnt] = DW'(n & ((1 << sh) - 1));
        cnt++;
        sn = n;
        sn = sn >>> sh;
        n  = sn;
      end
      if (cnt == lim) begin
        rem = VW - sh * (lim - 1);
        d[cnt-1] = d[cnt-1] & DW'((1 << rem) - 1);
      end
    end else begin
      base = (r < ltrd_pkg::RADIX_MIN) ? VW'(ltrd_pkg::RADIX_MIN) : VW'(r);
      if (s && n[VW-1]) begin
        k[cnt] = ltrd_pkg::KIND_SIGN;
        d[cnt] = '0;
        cnt++;
        n = '0 - n;
      end
      while (n != 0 && cnt < RUN_MAX) begin
        k[cnt] = ltrd_pkg::KIND_DIGIT;
        d[cnt] = DW'(n % base);
        cnt++;
        n = n / base;
      end
    end
    if (cnt == 0) begin
      k[0] = ltrd_pkg::KIND_ZERO;
      d[0] = '0;
      cnt  = 1;
    end
    for (int i = 0; i < cnt; i++) begin
      res.kind  = k[i];
      res.digit = d[i];
      res.last  = (i == cnt - 1);
      digits_pending.push_back(res);
    end
  endfunction

  // called at a rising edge; returns at the edge of the transfer
  task automatic send_item(input logic [VW-1:0] v, input logic [RW-1:0] r,
                           input logic s);
    int unsigned gap;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 4);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.radix     <= r;
    in_ch.is_signed <= s;
    do @(posedge clk); while (!in_ch.ready);
    predict_digits(v, r, s);
  endtask

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    case ($urandom_range(0, 6))
      0, 1: v = VW'($urandom);
      2:    v = VW'($urandom_range(0, 255));
      3:    v = '0 - VW'($urandom_range(1, 255));
      4: begin
        case ($urandom_range(0, 3))
          0:       v = {1'b1, {(VW-1){1'b0}}};
          1:       v = {1'b0, {(VW-1){1'b1}}};
          2:       v = '1;
          default: v = VW'(1);
        endcase
      end
      5:       v = '0;
      default: v = VW'($urandom >> $urandom_range(0, VW - 1));
    endcase
    return v;
  endfunction

  function automatic logic [RW-1:0] pick_radix();
    logic [RW-1:0] r;
    case ($urandom_range(0, 19))
      0, 1, 2, 3:    r = ltrd_pkg::RADIX_HEX;
      4, 5, 6, 7:    r = ltrd_pkg::RADIX_OCT;
      8, 9, 10:      r = RW'($urandom_range(0, 63));
      11, 12:        r = 6'd10;
      default:       r = RW'($urandom_range(2, 36));
    endcase
    return r;
  endfunction

  task automatic test_directed();
    send_item('0, 6'd10, 1'b1);
    send_item('0, ltrd_pkg::RADIX_HEX, 1'b0);
    send_item('0, ltrd_pkg::RADIX_OCT, 1'b1);
    send_item({1'b0, {(VW-1){1'b1}}}, 6'd10, 1'b1);
    send_item({1'b1, {(VW-1){1'b0}}}, 6'd10, 1'b1);
    send_item({1'b1, {(VW-1){1'b0}}}, 6'd10, 1'b0);
    send_item({1'b1, {(VW-1){1'b0}}}, ltrd_pkg::RADIX_MIN, 1'b1);
    send_item('1, ltrd_pkg::RADIX_MIN, 1'b0);
    send_item('1, ltrd_pkg::RADIX_MIN, 1'b1);
    send_item('1, ltrd_pkg::RADIX_HEX, 1'b1);
    send_item('1, ltrd_pkg::RADIX_OCT, 1'b0);
    send_item({1'b1, {(VW-1){1'b0}}}, ltrd_pkg::RADIX_OCT, 1'b0);
    send_item(32'h1234_5678, ltrd_pkg::RADIX_HEX, 1'b0);
    send_item(32'o1234_5670, ltrd_pkg::RADIX_OCT, 1'b1);
    send_item('0 - VW'(5), 6'd10, 1'b0);
    send_item('0 - VW'(5), ltrd_pkg::RADIX_HEX, 1'b1);
    send_item(VW'(1), ltrd_pkg::RADIX_MIN, 1'b0);
    send_item(32'h0000_0077, 6'd0, 1'b0);
    send_item('0 - VW'(77), 6'd1, 1'b1);
    send_item('1, 6'd63, 1'b0);
    send_item('1, 6'd36, 1'b0);
    send_item('0 - VW'(1000), 6'd37, 1'b1);
    send_item(VW'(35), 6'd36, 1'b0);
  endtask

  // output held off while the sender keeps offering short items
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_hold_req = 1'b1;
    for (int i = 0; i < 8; i++)
      send_item(VW'($urandom), (i % 2) ? ltrd_pkg::RADIX_HEX : ltrd_pkg::RADIX_OCT, 1'b0);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_idle(input int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_item(pick_value(), pick_radix(), 1'($urandom));
  endtask

  task automatic test_random_steady(input int unsigned count);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    for (int unsigned i = 0; i < count; i++)
      send_item(pick_value(), pick_radix(), 1'($urandom));
  endtask

  initial begin : rx_ready_ctl
    int unsigned n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (rx_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
        rx_hold_req = 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    digit_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (digits_pending.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind=%0d digit=%0d last=%0b",
                                  out_ch.kind, out_ch.digit, out_ch.last));
      end else begin
        exp_res = digits_pending.pop_front();
        if (out_ch.kind !== exp_res.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", out_ch.kind, exp_res.kind));
        if (out_ch.digit !== exp_res.digit)
          report_mismatch($sformatf("digit %0d, expected %0d", out_ch.digit,
                                    exp_res.digit));
        if (out_ch.last !== exp_res.last)
          report_mismatch($sformatf("last %0b, expected %0b", out_ch.last, exp_res.last));
      end
    end
  end

  initial begin
    #(20_000_000);
    $display("FAIL long_to_radix_digits_unit");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.radix     <= ltrd_pkg::RADIX_MIN;
    in_ch.is_signed <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_idle(190);
    test_random_steady(50);
    in_ch.valid <= 1'b0;
    while (digits_pending.size() != 0) @(posedge clk);
    repeat (2 * VW + 8) @(posedge clk);
    if (digits_pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", digits_pending.size()));
    if (mismatch_count == 0) begin
      $display("PASS long_to_radix_digits_unit");
    end else begin
      $display("FAIL long_to_radix_digits_unit");
    end
    $finish;
  end

endmodule
